/* rtl/core/pftb_pkg.sv */
`default_nettype none

package pftb_pkg;

    // Screen geometry in pixels.
    localparam int SCREEN_W = 128;
    localparam int SCREEN_H = 64;

    // Frame store: one byte per column per page of eight rows.
    localparam int STORE_DEPTH = 1024;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 8;

    // Field widths of the channels.
    localparam int OP_W    = 2;
    localparam int POS_W   = 10;
    localparam int GLYPH_W = 64;
    localparam int ADDR_W  = 10;
    localparam int BYTE_W  = 8;

    // Glyph is eight columns of eight pixels.
    localparam int GLYPH_COLS = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_BLIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/pftb_if.sv */
`default_nettype none

// Request channel: one beat is one operation.
interface pftb_in_if;
    logic                                valid;
    logic                                ready;
    logic        [pftb_pkg::OP_W-1:0]    op;
    logic signed [pftb_pkg::POS_W-1:0]   pos_x;
    logic signed [pftb_pkg::POS_W-1:0]   pos_y;
    logic        [pftb_pkg::GLYPH_W-1:0] glyph_bits;
    logic        [pftb_pkg::ADDR_W-1:0]  byte_addr;
    logic        [pftb_pkg::BYTE_W-1:0]  write_byte;

    modport source (
        output valid, op, pos_x, pos_y, glyph_bits, byte_addr, write_byte,
        input  ready
    );
    modport sink (
        input  valid, op, pos_x, pos_y, glyph_bits, byte_addr, write_byte,
        output ready
    );
endinterface

// Response channel: one beat per operation.
interface pftb_out_if;
    logic                          valid;
    logic                          ready;
    logic [pftb_pkg::BYTE_W-1:0]   read_byte;
    logic                          visible;

    modport source (
        output valid, read_byte, visible,
        input  ready
    );
    modport sink (
        input  valid, read_byte, visible,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/page_framebuffer_tile_blitter.sv */
`default_nettype none

// Channel   Port    Dir  Payload
// -------   ------  ---  -------------------------------------------------
// request   i_in    in   op, pos_x, pos_y, glyph_bits, byte_addr, write_byte
// response  o_out   out  read_byte, visible
//
// One operation at a time; the request side is ready only when idle and the
// response register is empty. A write passes S_START and S_DONE, a read also
// S_RDW; an off-screen blit goes from S_START to S_DONE, otherwise each byte
// outside the store is skipped and each other one is read, then OR-merged and
// written back (S_RD, S_WR) through the single RAM port, up to sixteen bytes.
// After reset a clearing pass writes zeros over all 1024 bytes, one per
// cycle, before the first request is taken. A stalled response holds its
// beat and blocks new requests.

module page_framebuffer_tile_blitter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pftb_in_if.sink    i_in,
    pftb_out_if.source o_out
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_RDW   = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Width of a blit address before the store-range check.
    localparam int BASE_W = $clog2((pftb_pkg::SCREEN_H / 8 + 1) * pftb_pkg::SCREEN_W + 1);
    localparam int CNT_W  = $clog2(pftb_pkg::GLYPH_COLS + 1);
    localparam int COL_AW = $clog2(pftb_pkg::GLYPH_COLS);
    localparam int SHF_W  = $clog2(pftb_pkg::PIX_W);
    localparam int SW     = pftb_pkg::POS_W + 2;

    localparam logic signed [SW-1:0] W_S   = SW'(pftb_pkg::SCREEN_W);
    localparam logic signed [SW-1:0] H_S   = SW'(pftb_pkg::SCREEN_H);
    localparam logic signed [SW-1:0] EDGE  = SW'(pftb_pkg::GLYPH_COLS - 1);
    localparam logic signed [SW-1:0] W_M8  = SW'(pftb_pkg::SCREEN_W - pftb_pkg::GLYPH_COLS);
    localparam logic signed [SW-1:0] H_M8  = SW'(pftb_pkg::SCREEN_H - pftb_pkg::GLYPH_COLS);

    // Control registers.
    logic [2:0]                       r_state, n_state;
    logic [pftb_pkg::STORE_AW-1:0]    r_clr, n_clr;
    logic                             r_out_valid, n_out_valid;

    // Operation and working registers.
    logic [pftb_pkg::OP_W-1:0]        r_op, n_op;
    logic signed [SW-1:0]             r_x, n_x;
    logic signed [SW-1:0]             r_y, n_y;
    logic [pftb_pkg::GLYPH_W-1:0]     r_glyph, n_glyph;
    logic [pftb_pkg::ADDR_W-1:0]      r_byte_addr, n_byte_addr;
    logic [pftb_pkg::BYTE_W-1:0]      r_wbyte, n_wbyte;
    logic [pftb_pkg::BYTE_W-1:0]      r_rd, n_rd;
    logic                             r_vis, n_vis;
    logic [CNT_W-1:0]                 r_col, n_col;
    logic [CNT_W-1:0]                 r_last, n_last;
    logic                             r_half, n_half;
    logic                             r_lo_en, n_lo_en;
    logic                             r_neg, n_neg;
    logic [BASE_W-1:0]                r_up_base, n_up_base;
    logic [BASE_W-1:0]                r_lo_base, n_lo_base;
    logic [pftb_pkg::STORE_AW-1:0]    r_wr_addr, n_wr_addr;
    logic [pftb_pkg::PIX_W-1:0]       r_wr_val, n_wr_val;

    // RAM port.
    logic                             ram_we;
    logic [pftb_pkg::STORE_AW-1:0]    ram_addr;
    logic [pftb_pkg::PIX_W-1:0]       ram_wdata;
    logic [pftb_pkg::PIX_W-1:0]       ram_rdata;

    // Shared shift and address unit.
    logic [pftb_pkg::PIX_W-1:0]       s_colbyte;
    logic [2*pftb_pkg::PIX_W-1:0]     s_wide;
    logic [pftb_pkg::PIX_W-1:0]       s_val;
    logic signed [SW-1:0]             s_sx;
    logic [BASE_W-1:0]                s_addr;
    logic                             s_in_store;
    logic                             s_vis;
    logic                             in_acc;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid     = r_out_valid;
    assign o_out.read_byte = r_rd;
    assign o_out.visible   = r_vis;

    // Column byte shifted by the row offset; the two halves feed the two pages.
    // Above the top edge the high half lands in page 0.
    assign s_colbyte = r_glyph[{r_col[COL_AW-1:0], SHF_W'(0)} +: pftb_pkg::PIX_W];
    assign s_wide    = {{pftb_pkg::PIX_W{1'b0}}, s_colbyte} << r_y[SHF_W-1:0];
    assign s_val     = (r_half || r_neg) ? s_wide[2*pftb_pkg::PIX_W-1:pftb_pkg::PIX_W]
                                         : s_wide[pftb_pkg::PIX_W-1:0];
    assign s_sx       = r_x + SW'(r_col);
    assign s_addr     = (r_half ? r_lo_base : r_up_base) + BASE_W'(s_sx);
    assign s_in_store = 32'(s_addr) < pftb_pkg::STORE_DEPTH;

    // Clip window test.
    assign s_vis = (r_x >= -EDGE) && (r_x < W_S) && (r_y >= -EDGE) && (r_y < H_S);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_x         = r_x;
        n_y         = r_y;
        n_glyph     = r_glyph;
        n_byte_addr = r_byte_addr;
        n_wbyte     = r_wbyte;
        n_rd        = r_rd;
        n_vis       = r_vis;
        n_col       = r_col;
        n_last      = r_last;
        n_half      = r_half;
        n_lo_en     = r_lo_en;
        n_neg       = r_neg;
        n_up_base   = r_up_base;
        n_lo_base   = r_lo_base;
        n_wr_addr   = r_wr_addr;
        n_wr_val    = r_wr_val;
        ram_we      = 1'b0;
        ram_addr    = r_wr_addr;
        ram_wdata   = ram_rdata | r_wr_val;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op        = i_in.op;
                    n_x         = SW'(i_in.pos_x);
                    n_y         = SW'(i_in.pos_y);
                    n_glyph     = i_in.glyph_bits;
                    n_byte_addr = i_in.byte_addr;
                    n_wbyte     = i_in.write_byte;
                    n_rd        = '0;
                    n_vis       = 1'b0;
                    n_state     = S_START;
                end
            end
            S_START: begin
                n_state = S_DONE;
                unique case (r_op)
                    pftb_pkg::OP_BLIT: begin
                        n_vis     = s_vis;
                        n_neg     = r_y < 0;
                        n_half    = 1'b0;
                        n_col     = (r_x < 0) ? CNT_W'(-r_x) : '0;
                        n_last    = (r_x > W_M8) ? CNT_W'(W_S - r_x)
                                                 : CNT_W'(pftb_pkg::GLYPH_COLS);
                        n_lo_en   = (r_y >= 0) && (r_y[SHF_W-1:0] != '0) && (r_y <= H_M8);
                        n_up_base = (r_y < 0) ? '0
                                    : BASE_W'(32'(r_y[SW-2:SHF_W]) * pftb_pkg::SCREEN_W);
                        n_lo_base = n_up_base + BASE_W'(pftb_pkg::SCREEN_W);
                        if (s_vis) begin
                            n_state = S_RD;
                        end
                    end
                    pftb_pkg::OP_WRITE: begin
                        ram_we    = 1'b1;
                        ram_addr  = r_byte_addr;
                        ram_wdata = r_wbyte;
                    end
                    pftb_pkg::OP_READ: begin
                        ram_addr = r_byte_addr;
                        n_state  = S_RDW;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RDW: begin
                n_rd    = ram_rdata;
                n_state = S_DONE;
            end
            S_RD: begin
                if (r_col >= r_last) begin
                    n_state = S_DONE;
                end else if (s_in_store) begin
                    // Fetch the target byte for the merge.
                    ram_addr  = s_addr[pftb_pkg::STORE_AW-1:0];
                    n_wr_addr = s_addr[pftb_pkg::STORE_AW-1:0];
                    n_wr_val  = s_val;
                    n_state   = S_WR;
                end else if (!r_half && r_lo_en) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_col  = r_col + 1'b1;
                end
            end
            S_WR: begin
                // OR the glyph bits into the fetched byte.
                ram_we  = 1'b1;
                n_state = S_RD;
                if (!r_half && r_lo_en) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    n_col  = r_col + 1'b1;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_x         <= n_x;
        r_y         <= n_y;
        r_glyph     <= n_glyph;
        r_byte_addr <= n_byte_addr;
        r_wbyte     <= n_wbyte;
        r_rd        <= n_rd;
        r_vis       <= n_vis;
        r_col       <= n_col;
        r_last      <= n_last;
        r_half      <= n_half;
        r_lo_en     <= n_lo_en;
        r_neg       <= n_neg;
        r_up_base   <= n_up_base;
        r_lo_base   <= n_lo_base;
        r_wr_addr   <= n_wr_addr;
        r_wr_val    <= n_wr_val;
    end

    // Frame store.
    pftb_ram #(
        .WIDTH (pftb_pkg::PIX_W),
        .DEPTH (pftb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // A merge write always follows the fetch of the same byte.
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("merge write without a preceding fetch");

    // A merge only happens on a glyph column inside the glyph.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_col < CNT_W'(pftb_pkg::GLYPH_COLS)))
        else $error("column counter beyond glyph width");

    // An accepted request never yields a response on the very next edge.
    a_no_early_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !r_out_valid)
        else $error("response raised without processing");

    // No request is taken while the store is being cleared.
    a_no_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("request accepted during clearing pass");

endmodule

`default_nettype wire

/* rtl/core/pftb_ram.sv */
`default_nettype none

// Single-port RAM with registered read data.
module pftb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One access per cycle, read data appears on the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
    import pftb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 60;
    // Once this few requests remain, no new idle or stall burst starts.
    localparam int STEADY_TAIL  = 40;

    typedef struct {
        logic        [OP_W-1:0]    op;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic        [GLYPH_W-1:0] glyph_bits;
        logic        [ADDR_W-1:0]  byte_addr;
        logic        [BYTE_W-1:0]  write_byte;
    } req_t;

    typedef struct {
        logic [BYTE_W-1:0] read_byte;
        logic              visible;
    } rsp_t;

    logic i_clk;
    logic i_rst_n;

    pftb_in_if  req_if ();
    pftb_out_if rsp_if ();

    page_framebuffer_tile_blitter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Shadow copy of the frame store and the queues around the block.
    logic [BYTE_W-1:0] frame_model [STORE_DEPTH];
    req_t pending_reqs [$];
    rsp_t predicted_rsps [$];

    int mismatches = 0;
    int cycles = 0;

    // Clock generation.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // ORs one byte into the shadow store; addresses beyond the store are dropped.
    function automatic void or_pixels(int addr, logic [BYTE_W-1:0] bits);
        if (addr >= 0 && addr < STORE_DEPTH) begin
            frame_model[STORE_AW'(addr)] = frame_model[STORE_AW'(addr)] | bits;
        end
    endfunction

    // Blits a glyph of GLYPH_COLS column bytes at a signed position with clipping on every screen edge.
    function automatic logic blit_glyph(int x, int y, logic [GLYPH_W-1:0] glyph);
        int first_col;
        int last_col;
        int sx;
        int page;
        int shift;
        logic [BYTE_W-1:0] col;
        if (x < -7 || x >= SCREEN_W || y < -7 || y >= SCREEN_H) begin
            return 1'b0;
        end
        first_col = (x < 0) ? -x : 0;
        last_col  = (x > SCREEN_W - 8) ? (SCREEN_W - x) : GLYPH_COLS;
        for (int c = first_col; c < last_col; c++) begin
            col = glyph[8*c +: 8];
            sx  = x + c;
            if (y < 0) begin
                // Partly above the screen: only page 0 sees the lower rows.
                or_pixels(sx, col >> (-y));
            end else begin
                page  = y / 8;
                shift = y % 8;
                or_pixels(page * SCREEN_W + sx, col << shift);
                if (shift != 0 && y <= SCREEN_H - 8) begin
                    or_pixels((page + 1) * SCREEN_W + sx, col >> (8 - shift));
                end
            end
        end
        return 1'b1;
    endfunction

    // Applies one request to the shadow store and returns its response.
    function automatic rsp_t predict_response(req_t r);
        rsp_t res;
        res.read_byte = '0;
        res.visible   = 1'b0;
        case (r.op)
            OP_BLIT: begin
                res.visible = blit_glyph(int'(r.pos_x), int'(r.pos_y), r.glyph_bits);
            end
            OP_WRITE: begin
                frame_model[r.byte_addr] = r.write_byte;
            end
            OP_READ: begin
                res.read_byte = frame_model[r.byte_addr];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Queues one request; the caller supplies every field, also those that the op ignores.
    task automatic add_req(logic [OP_W-1:0] op, int x, int y,
                           logic [GLYPH_W-1:0] glyph, int addr, int wbyte);
        req_t r;
        r.op         = op;
        r.pos_x      = POS_W'(x);
        r.pos_y      = POS_W'(y);
        r.glyph_bits = glyph;
        r.byte_addr  = ADDR_W'(addr);
        r.write_byte = BYTE_W'(wbyte);
        pending_reqs.push_back(r);
    endtask

    function automatic logic [GLYPH_W-1:0] rand_glyph();
        return {$urandom, $urandom};
    endfunction

    // Request driver: holds a beat until taken, idles in random bursts.
    int   gap_left = 0;
    int   gap_pct  = 0;
    int   sent     = 0;
    req_t seen_req;
    req_t next_req;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                seen_req.op         = req_if.op;
                seen_req.pos_x      = req_if.pos_x;
                seen_req.pos_y      = req_if.pos_y;
                seen_req.glyph_bits = req_if.glyph_bits;
                seen_req.byte_addr  = req_if.byte_addr;
                seen_req.write_byte = req_if.write_byte;
                predicted_rsps.push_back(predict_response(seen_req));
                sent++;
                // Change the idling density now and then, including none at all.
                if (sent % 48 == 0) begin
                    gap_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 45);
                end
            end
            if (req_if.valid && !req_if.ready) begin
                // Beat still waiting: hold everything.
            end else if (gap_left > 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > STEADY_TAIL &&
                         $urandom_range(99) < gap_pct) begin
                gap_left = $urandom_range(1, 10) - 1;
                req_if.valid <= 1'b0;
            end else begin
                next_req = pending_reqs.pop_front();
                req_if.valid      <= 1'b1;
                req_if.op         <= next_req.op;
                req_if.pos_x      <= next_req.pos_x;
                req_if.pos_y      <= next_req.pos_y;
                req_if.glyph_bits <= next_req.glyph_bits;
                req_if.byte_addr  <= next_req.byte_addr;
                req_if.write_byte <= next_req.write_byte;
            end
        end
    end

    // Response monitor: stalls in random bursts and checks every beat.
    int   stall_left = 0;
    int   stall_pct  = 0;
    int   received   = 0;
    rsp_t want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                received++;
                if (received % 40 == 0) begin
                    stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 45);
                end
                if (predicted_rsps.size() == 0) begin
                    $error("response beat with none outstanding: read_byte %0h visible %0b",
                           rsp_if.read_byte, rsp_if.visible);
                    mismatches++;
                end else begin
                    want = predicted_rsps.pop_front();
                    if (rsp_if.read_byte !== want.read_byte) begin
                        $error("read_byte: expected %0h, got %0h",
                               want.read_byte, rsp_if.read_byte);
                        mismatches++;
                    end
                    if (rsp_if.visible !== want.visible) begin
                        $error("visible: expected %0b, got %0b",
                               want.visible, rsp_if.visible);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (pending_reqs.size() > STEADY_TAIL &&
                         $urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int sel;
        int x;
        int y;
        logic [OP_W-1:0] op;

        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.op         = OP_NONE;
        req_if.pos_x      = '0;
        req_if.pos_y      = '0;
        req_if.glyph_bits = '0;
        req_if.byte_addr  = '0;
        req_if.write_byte = '0;
        rsp_if.ready      = 1'b0;
        for (int a = 0; a < STORE_DEPTH; a++) begin
            frame_model[STORE_AW'(a)] = '0;
        end

        // Directed part: single-byte ops at the address extremes.
        add_req(OP_WRITE, 0, 0, rand_glyph(), 0, 8'hFF);
        add_req(OP_READ, 0, 0, rand_glyph(), 0, 0);
        add_req(OP_WRITE, 0, 0, rand_glyph(), 1023, 8'hA5);
        add_req(OP_READ, 0, 0, rand_glyph(), 1023, 0);
        add_req(OP_WRITE, 0, 0, rand_glyph(), 0, 8'h00);
        // Aligned row, all pixels set, then read back.
        add_req(OP_BLIT, 0, 0, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_READ, 0, 0, rand_glyph(), 7, 0);
        // Row split across two pages, then read both halves.
        add_req(OP_BLIT, 20, 3, 64'h8142_2418_1824_4281, 0, 0);
        add_req(OP_READ, 0, 0, rand_glyph(), 20, 0);
        add_req(OP_READ, 0, 0, rand_glyph(), SCREEN_W + 20, 0);
        // Top-left corner partly above and left of the screen.
        add_req(OP_BLIT, -7, -7, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_READ, 0, 0, rand_glyph(), 0, 0);
        // Right and bottom clipping, aligned bottom page.
        add_req(OP_BLIT, 127, 63, rand_glyph(), 0, 0);
        add_req(OP_BLIT, 120, 56, rand_glyph(), 0, 0);
        add_req(OP_BLIT, 50, 60, rand_glyph(), 0, 0);
        add_req(OP_READ, 0, 0, rand_glyph(), 7 * SCREEN_W + 50, 0);
        // Tiles fully off screen on each side, including just past the right edge.
        add_req(OP_BLIT, -8, 0, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_BLIT, 128, 10, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_BLIT, 134, 10, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_BLIT, 30, -8, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_BLIT, 30, 64, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_BLIT, -512, -512, {GLYPH_W{1'b1}}, 0, 0);
        add_req(OP_BLIT, 511, 511, {GLYPH_W{1'b1}}, 0, 0);
        // Unused op code.
        add_req(OP_NONE, $urandom_range(1023), $urandom_range(1023), rand_glyph(),
                $urandom_range(1023), $urandom_range(255));

        // Random part, mostly blits around the screen with reads to observe them.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(99);
            x   = $urandom_range(1023);
            y   = $urandom_range(1023);
            if (sel < 52) begin
                op = OP_BLIT;
                x  = $urandom_range(0, 147) - 10;
                y  = $urandom_range(0, 79) - 10;
            end else if (sel < 60) begin
                op = OP_BLIT;
            end else if (sel < 73) begin
                op = OP_WRITE;
            end else if (sel < 97) begin
                op = OP_READ;
            end else begin
                op = OP_NONE;
            end
            // Half of the writes clear a byte so the screen does not saturate.
            add_req(op, x, y, rand_glyph(), $urandom_range(1023),
                    ($urandom_range(1) == 0) ? 0 : $urandom_range(255));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_if.valid) @(posedge i_clk);
        while (predicted_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
